>>> rtl/core/tfcc_pkg.sv
package tfcc_pkg;

    localparam int BYTE_BITS      = 8;
    localparam int RANGE_BITS     = 32;
    localparam int BOUND_BITS     = 16;
    localparam int CFG_INDEX_BITS = 3;

    localparam logic [BYTE_BITS-1:0] NL_BYTE  = 8'd10;
    localparam logic [BYTE_BITS-1:0] TAB_BYTE = 8'd9;

    localparam logic KIND_TEXT   = 1'b0;
    localparam logic KIND_END    = 1'b1;
    localparam logic MODE_COLUMN = 1'b0;
    localparam logic MODE_FIELD  = 1'b1;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_SELECT_MODE    = 3'd0,
        REG_DELIMITER      = 3'd1,
        REG_SUPPRESS_PLAIN = 3'd2,
        REG_RANGE_ZERO     = 3'd3,
        REG_RANGE_ONE      = 3'd4,
        REG_RANGE_TWO      = 3'd5,
        REG_RANGE_THREE    = 3'd6
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FLUSH_RD,
        ST_FLUSH_WR,
        ST_TAIL
    } cut_state_t;

    typedef struct packed {
        logic                 kind;
        logic [BYTE_BITS-1:0] text_byte;
    } text_item_t;

    typedef struct packed {
        logic [BYTE_BITS-1:0] out_byte;
        logic                 run_last;
        logic                 overflowed;
    } cut_item_t;

endpackage

>>> rtl/core/tfcc_hold_ram.sv
module tfcc_hold_ram
    import tfcc_pkg::*;
#(
    parameter int DEPTH     = 63,
    parameter int ADDR_BITS = 6
)
(
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [BYTE_BITS-1:0] wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [BYTE_BITS-1:0] rdata
);

    logic [BYTE_BITS-1:0] mem [DEPTH];
    logic [BYTE_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/tfcc_range_match.sv
module tfcc_range_match
    import tfcc_pkg::*;
#(
    parameter int RANGE_COUNT   = 4,
    parameter int POSITION_BITS = 16
)
(
    input  logic [RANGE_COUNT-1:0][RANGE_BITS-1:0] ranges,
    input  logic [POSITION_BITS-1:0]               pos,
    output logic                                   hit
);

    logic [BOUND_BITS-1:0]  pos_ext;
    logic [RANGE_COUNT-1:0] hits;

    assign pos_ext = BOUND_BITS'(pos);

    always_comb
    begin
        for (int i = 0; i < RANGE_COUNT; i++)
        begin
            hits[i] = (ranges[i][BOUND_BITS-1:0] != '0)
                   && (ranges[i][BOUND_BITS-1:0] <= pos_ext)
                   && (pos_ext <= ranges[i][RANGE_BITS-1:BOUND_BITS]);
        end
    end

    assign hit = |hits;

endmodule

>>> rtl/core/text_field_column_cutter.sv
// A result reaches the output register in the cycle after its item is taken.
// Throughput: one item per cycle while each item yields at most one result and the output slot is free.
// An item that releases a held first field of N bytes blocks the input while its
// bytes go out through ST_FLUSH_RD and ST_FLUSH_WR, then through ST_TAIL when a byte
// follows them; ST_FLUSH_RD starts the registered read of the hold memory first.
// Reset (rst_n, async, active low) clears line state and restores register defaults;
// the hold memory is not cleared.
module text_field_column_cutter
    import tfcc_pkg::*;
#(
    parameter int HOLD_DEPTH    = 63,
    parameter int RANGE_COUNT   = 4,
    parameter int POSITION_BITS = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      text_valid,
    output logic                      text_ready,
    input  text_item_t                text_item,
    output logic                      cut_valid,
    input  logic                      cut_ready,
    output cut_item_t                 cut_item,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [RANGE_BITS-1:0]     cfg_data
);

    localparam int CW = $clog2(HOLD_DEPTH + 1);
    localparam int AW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;

    // configuration
    logic                                   select_mode_reg;
    logic [BYTE_BITS-1:0]                   delimiter_reg;
    logic                                   suppress_reg;
    logic [RANGE_COUNT-1:0][RANGE_BITS-1:0] range_reg;

    // line state
    cut_state_t               state_reg, state_next;
    logic [POSITION_BITS-1:0] col_reg, col_next;
    logic [POSITION_BITS-1:0] field_reg, field_next;
    logic                     emitted_reg, emitted_next;
    logic                     seen_reg, seen_next;
    logic                     open_reg, open_next;
    logic [CW-1:0]            count_reg, count_next;
    logic                     lost_reg, lost_next;

    // burst state
    logic [CW-1:0]            fcount_reg, fcount_next;
    logic [CW-1:0]            idx_reg, idx_next;
    logic                     pend_v_reg, pend_v_next;
    logic [BYTE_BITS-1:0]     pend_b_reg, pend_b_next;
    logic                     item_lost_reg, item_lost_next;

    logic                     out_valid_reg, out_valid_next;
    cut_item_t                out_item_reg, out_item_next;

    logic                     slot_free;
    logic                     text_fire;
    logic                     is_end, is_nl, is_delim, is_byte, is_end_line;
    logic [POSITION_BITS-1:0] col_inc, fld_inc, fld_inc2, pos_a;
    logic                     match_a, match_one;
    logic                     flush, tail_v;
    logic [BYTE_BITS-1:0]     tail_b;
    logic [CW-1:0]            idx_plus;

    logic                     ram_we, ram_re;
    logic [AW-1:0]            ram_raddr;
    logic [BYTE_BITS-1:0]     ram_rdata;

    assign slot_free  = !out_valid_reg || cut_ready;
    assign text_ready = (state_reg == ST_IDLE) && slot_free;
    assign text_fire  = text_valid && text_ready;
    assign cut_valid  = out_valid_reg;
    assign cut_item   = out_item_reg;

    assign is_end      = (text_item.kind == KIND_END);
    assign is_nl       = !is_end && (text_item.text_byte == NL_BYTE);
    assign is_byte     = !is_end && !is_nl;
    assign is_delim    = (text_item.text_byte == delimiter_reg);
    assign is_end_line = is_end ? open_reg : is_nl;

    assign col_inc  = (&col_reg) ? col_reg : col_reg + 1'b1;
    assign fld_inc  = (&field_reg) ? field_reg : field_reg + 1'b1;
    assign fld_inc2 = (&fld_inc) ? fld_inc : fld_inc + 1'b1;
    assign pos_a    = (select_mode_reg == MODE_COLUMN) ? col_inc
                    : (is_delim ? fld_inc2 : fld_inc);
    assign idx_plus = idx_reg + CW'(1);

    tfcc_range_match #(
        .RANGE_COUNT   (RANGE_COUNT),
        .POSITION_BITS (POSITION_BITS)
    ) u_match_a (
        .ranges (range_reg),
        .pos    (pos_a),
        .hit    (match_a)
    );

    tfcc_range_match #(
        .RANGE_COUNT   (RANGE_COUNT),
        .POSITION_BITS (POSITION_BITS)
    ) u_match_one (
        .ranges (range_reg),
        .pos    (POSITION_BITS'(1)),
        .hit    (match_one)
    );

    tfcc_hold_ram #(
        .DEPTH     (HOLD_DEPTH),
        .ADDR_BITS (AW)
    ) u_hold_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (text_item.text_byte),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            select_mode_reg <= MODE_COLUMN;
            delimiter_reg   <= TAB_BYTE;
            suppress_reg    <= 1'b0;
            range_reg       <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SELECT_MODE:    select_mode_reg <= cfg_data[0];
                REG_DELIMITER:      delimiter_reg   <= cfg_data[BYTE_BITS-1:0];
                REG_SUPPRESS_PLAIN: suppress_reg    <= cfg_data[0];
                default:
                begin
                    for (int i = 0; i < RANGE_COUNT; i++)
                    begin
                        if (cfg_index == CFG_INDEX_BITS'(REG_RANGE_ZERO + i))
                        begin
                            range_reg[i] <= cfg_data;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            col_reg       <= '0;
            field_reg     <= '0;
            emitted_reg   <= 1'b0;
            seen_reg      <= 1'b0;
            open_reg      <= 1'b0;
            count_reg     <= '0;
            lost_reg      <= 1'b0;
            fcount_reg    <= '0;
            idx_reg       <= '0;
            pend_v_reg    <= 1'b0;
            item_lost_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            field_reg     <= field_next;
            emitted_reg   <= emitted_next;
            seen_reg      <= seen_next;
            open_reg      <= open_next;
            count_reg     <= count_next;
            lost_reg      <= lost_next;
            fcount_reg    <= fcount_next;
            idx_reg       <= idx_next;
            pend_v_reg    <= pend_v_next;
            item_lost_reg <= item_lost_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_b_reg   <= pend_b_next;
        out_item_reg <= out_item_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        col_next       = col_reg;
        field_next     = field_reg;
        emitted_next   = emitted_reg;
        seen_next      = seen_reg;
        open_next      = open_reg;
        count_next     = count_reg;
        lost_next      = lost_reg;
        fcount_next    = fcount_reg;
        idx_next       = idx_reg;
        pend_v_next    = pend_v_reg;
        pend_b_next    = pend_b_reg;
        item_lost_next = item_lost_reg;
        out_valid_next = out_valid_reg && !cut_ready;
        out_item_next  = out_item_reg;
        flush          = 1'b0;
        tail_v         = 1'b0;
        tail_b         = text_item.text_byte;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_raddr      = idx_reg[AW-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (text_fire)
                begin
                    if (is_end_line)
                    begin
                        if (select_mode_reg == MODE_COLUMN)
                        begin
                            tail_v = 1'b1;
                            tail_b = NL_BYTE;
                        end
                        else if (!seen_reg)
                        begin
                            if (!suppress_reg)
                            begin
                                flush  = 1'b1;
                                tail_v = 1'b1;
                                tail_b = NL_BYTE;
                            end
                        end
                        else if (emitted_reg)
                        begin
                            tail_v = 1'b1;
                            tail_b = NL_BYTE;
                        end
                        col_next     = '0;
                        field_next   = '0;
                        emitted_next = 1'b0;
                        seen_next    = 1'b0;
                        open_next    = 1'b0;
                        count_next   = '0;
                        lost_next    = 1'b0;
                    end
                    else if (is_byte)
                    begin
                        open_next = 1'b1;
                        if (select_mode_reg == MODE_COLUMN)
                        begin
                            col_next = col_inc;
                            tail_v   = match_a;
                        end
                        else if (is_delim)
                        begin
                            if (!seen_reg && match_one)
                            begin
                                flush        = 1'b1;
                                emitted_next = 1'b1;
                            end
                            seen_next  = 1'b1;
                            field_next = fld_inc;
                            if (match_a)
                            begin
                                tail_v       = emitted_next;
                                tail_b       = delimiter_reg;
                                emitted_next = 1'b1;
                            end
                        end
                        else if (!seen_reg)
                        begin
                            if (count_reg < CW'(HOLD_DEPTH))
                            begin
                                ram_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                            else
                            begin
                                lost_next = 1'b1;
                            end
                        end
                        else
                        begin
                            tail_v = match_a;
                        end
                    end

                    if (flush && (count_reg != '0))
                    begin
                        pend_v_next    = tail_v;
                        pend_b_next    = tail_b;
                        fcount_next    = count_reg;
                        item_lost_next = lost_reg;
                        state_next     = ST_FLUSH_RD;
                    end
                    else if (tail_v)
                    begin
                        out_valid_next           = 1'b1;
                        out_item_next.out_byte   = tail_b;
                        out_item_next.run_last   = 1'b1;
                        out_item_next.overflowed = lost_reg;
                    end
                end
            end

            ST_FLUSH_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = '0;
                idx_next   = '0;
                state_next = ST_FLUSH_WR;
            end

            ST_FLUSH_WR:
            begin
                if (slot_free)
                begin
                    out_valid_next           = 1'b1;
                    out_item_next.out_byte   = ram_rdata;
                    out_item_next.run_last   = (idx_plus == fcount_reg) && !pend_v_reg;
                    out_item_next.overflowed = item_lost_reg;
                    if (idx_plus < fcount_reg)
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = idx_plus[AW-1:0];
                        idx_next  = idx_plus;
                    end
                    else
                    begin
                        state_next = pend_v_reg ? ST_TAIL : ST_IDLE;
                    end
                end
            end

            ST_TAIL:
            begin
                if (slot_free)
                begin
                    out_valid_next           = 1'b1;
                    out_item_next.out_byte   = pend_b_reg;
                    out_item_next.run_last   = 1'b1;
                    out_item_next.overflowed = item_lost_reg;
                    state_next               = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/tfcc_checker.sv
module tfcc_checker
    import tfcc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       text_valid,
    input logic       text_ready,
    input text_item_t text_item,
    input logic       cut_valid,
    input logic       cut_ready,
    input cut_item_t  cut_item
);

    // stalled result holds
    a_cut_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cut_valid && !cut_ready |=> cut_valid && $stable(cut_item))
        else $error("result changed while stalled");

    // no new item while a burst is still going out
    a_burst_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cut_valid && !cut_item.run_last |-> !text_ready)
        else $error("item taken during burst");

    // an item is only taken when the output slot can take its result
    a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        text_ready |-> (!cut_valid || cut_ready))
        else $error("item taken with output slot full");

    // overflow flag is constant across one item's burst
    a_flag_steady: assert property (@(posedge clk) disable iff (!rst_n)
        cut_valid && cut_ready && !cut_item.run_last |=>
            !cut_valid || (cut_item.overflowed == $past(cut_item.overflowed)))
        else $error("overflow flag changed within burst");

endmodule

bind text_field_column_cutter tfcc_checker u_tfcc_checker (.*);
